FILE: rtl/vkvl_pkg.sv
// ----------------------------------------------------------------------------
// vkvl_pkg
// Shared widths, codes and controller/datapath types for the versioned
// key/value lookup core.
// ----------------------------------------------------------------------------
package vkvl_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int TIME_W  = 31;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 32;

  typedef enum logic {
    ACT_SET = 1'b0,
    ACT_GET = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } vkvl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_busy;
  } vkvl_stat_t;

endpackage

FILE: rtl/vkvl_if.sv
// ----------------------------------------------------------------------------
// vkvl_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface vkvl_req_if
  import vkvl_pkg::*;
();
  logic               valid;
  logic               ready;
  action_t            action;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [TIME_W-1:0]  timestamp;

  modport source (output valid, action, key, value, timestamp, input ready);
  modport sink   (input valid, action, key, value, timestamp, output ready);
endinterface

interface vkvl_rsp_if
  import vkvl_pkg::*;
();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [VALUE_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

FILE: rtl/vkvl_datapath.sv
// ----------------------------------------------------------------------------
// vkvl_datapath
// Version table memory, request registers, scan counter, match logic and
// response register.
// ----------------------------------------------------------------------------
module vkvl_datapath
  import vkvl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  vkvl_cmd_t          cmd,
  output vkvl_stat_t         stat,
  input  action_t            req_action,
  input  logic [KEY_W-1:0]   req_key_in,
  input  logic [VALUE_W-1:0] req_value_in,
  input  logic [TIME_W-1:0]  req_time_in,
  input  logic               out_ready,
  output logic               out_valid,
  output status_t            out_status,
  output logic [VALUE_W-1:0] out_value
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  logic [KW-1:0]     mem_key  [TABLE_DEPTH];
  logic [TIME_W-1:0] mem_time [TABLE_DEPTH];
  logic [VW-1:0]     mem_val  [TABLE_DEPTH];

  action_t           act;
  logic [KW-1:0]     key;
  logic [VW-1:0]     val;
  logic [TIME_W-1:0] qtime;

  logic [FW-1:0]     fill;
  logic [FW-1:0]     cnt;
  logic              rd_pend;
  logic [KW-1:0]     rd_key;
  logic [TIME_W-1:0] rd_time;
  logic [VW-1:0]     rd_val;

  logic              found;
  logic              dup;
  logic [TIME_W-1:0] best_t;
  logic [VW-1:0]     best_v;

  logic              rd_en;
  logic              full;
  logic              wr_en;
  logic              key_hit;
  status_t           status_next;
  logic [VALUE_W-1:0] value_next;

  assign rd_en   = cmd.scan && (cnt != fill);
  assign full    = (fill == FW'(TABLE_DEPTH));
  assign wr_en   = cmd.commit && (act == ACT_SET) && !dup && !full;
  assign key_hit = (rd_key == key);

  assign stat.scan_end = (cnt == fill) && !rd_pend;
  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    status_next = ST_OK;
    value_next  = '0;
    if (act == ACT_SET) begin
      if (dup) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end
    end else if (found) begin
      value_next = VALUE_W'(best_v);
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[fill[AW-1:0]]  <= key;
      mem_time[fill[AW-1:0]] <= qtime;
      mem_val[fill[AW-1:0]]  <= val;
    end
    if (rd_en) begin
      rd_key  <= mem_key[cnt[AW-1:0]];
      rd_time <= mem_time[cnt[AW-1:0]];
      rd_val  <= mem_val[cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= req_action;
      key   <= req_key_in[KW-1:0];
      val   <= req_value_in[VW-1:0];
      qtime <= req_time_in;
    end
    if (!cmd.load && rd_pend && key_hit && (rd_time <= qtime) &&
        (!found || (rd_time > best_t))) begin
      best_t <= rd_time;
      best_v <= rd_val;
    end
    if (cmd.commit) begin
      out_status <= status_next;
      out_value  <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      dup       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt     <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
        dup     <= 1'b0;
      end else begin
        rd_pend <= rd_en;
        if (rd_en) begin
          cnt <= cnt + FW'(1);
        end
        if (rd_pend && key_hit) begin
          if (rd_time == qtime) begin
            dup <= 1'b1;
          end
          if (rd_time <= qtime) begin
            found <= 1'b1;
          end
        end
      end
      if (wr_en) begin
        fill <= fill + FW'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= fill)
    else $error("scan index beyond fill count");

  a_commit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("response overwritten while held");

  a_fill_commit : assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(fill))
    else $error("fill count moved without a commit");

  a_commit_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit gave no response");
`endif

endmodule

FILE: rtl/vkvl_ctrl.sv
// ----------------------------------------------------------------------------
// vkvl_ctrl
// Request sequencer: accept, scan the filled table, commit the response.
// ----------------------------------------------------------------------------
module vkvl_ctrl
  import vkvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  vkvl_stat_t stat,
  output vkvl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.commit = !stat.out_busy;
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/versioned_key_value_lookup_core.sv
// ----------------------------------------------------------------------------
// versioned_key_value_lookup_core
// Table of timestamped key/value versions with set and latest-at-time get.
//
//   channel  dir  payload                          transfer
//   req      in   action, key, value, timestamp    req.valid && req.ready
//   rsp      out  status, read_value               rsp.valid && rsp.ready
//
// A request runs a scan of the filled table through its single registered
// read port, one entry a cycle, then drains the last read before the commit.
// Reset empties the table at once; no clearing pass.
// A response waits in its own register; the next request is taken meanwhile
// and holds in its final cycle until that response is transferred.
// ----------------------------------------------------------------------------
module versioned_key_value_lookup_core
  import vkvl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input logic      clk,
  input logic      rst,
  vkvl_req_if.sink req,
  vkvl_rsp_if.source rsp
);

  vkvl_cmd_t  cmd;
  vkvl_stat_t stat;

  vkvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vkvl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_action   (req.action),
    .req_key_in   (req.key),
    .req_value_in (req.value),
    .req_time_in  (req.timestamp),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_status   (rsp.status),
    .out_value    (rsp.read_value)
  );

endmodule
